// ===== design/tce_pkg.sv =====
// ----------------------------------------------------------------------------
// tce_pkg
// Shared widths, opcodes and types of the toy CPU execute unit.
// ----------------------------------------------------------------------------
package tce_pkg;

    localparam int CMD_W       = 3;
    localparam int REG_FIELD_W = 3;
    localparam int REG_FIELD_N = 2 ** REG_FIELD_W;
    localparam int DATA_W      = 32;
    localparam int PC_W        = 8;

    localparam logic [CMD_W-1:0] CMD_LD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ST  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD = 3'd2;
    localparam logic [CMD_W-1:0] CMD_IMM = 3'd3;
    localparam logic [CMD_W-1:0] CMD_JMP = 3'd4;
    localparam logic [CMD_W-1:0] CMD_BNE = 3'd5;

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [PC_W-1:0]   t_pc;

endpackage

// ===== design/tce_if.sv =====
// ----------------------------------------------------------------------------
// tce_if
// Valid/ready channels of the execute unit: instruction in, result out.
// ----------------------------------------------------------------------------
interface tce_instr_if import tce_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [REG_FIELD_W-1:0]   dest_reg;
    logic [REG_FIELD_W-1:0]   src_a_reg;
    logic [REG_FIELD_W-1:0]   src_b_reg;
    logic signed [DATA_W-1:0] immediate;
    t_pc                      jump_target;

    modport source (
        output valid, command, dest_reg, src_a_reg, src_b_reg, immediate, jump_target,
        input  ready
    );
    modport sink (
        input  valid, command, dest_reg, src_a_reg, src_b_reg, immediate, jump_target,
        output ready
    );
endinterface

interface tce_result_if import tce_pkg::*; ();
    logic                     valid;
    logic                     ready;
    t_pc                      next_pc;
    logic                     redirect;
    logic                     reg_written;
    logic signed [DATA_W-1:0] write_value;

    modport source (
        output valid, next_pc, redirect, reg_written, write_value,
        input  ready
    );
    modport sink (
        input  valid, next_pc, redirect, reg_written, write_value,
        output ready
    );
endinterface

// ===== design/tce_ram.sv =====
// ----------------------------------------------------------------------------
// tce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/toy_cpu_execute_unit.sv =====
// ----------------------------------------------------------------------------
// toy_cpu_execute_unit
// Executes one decoded instruction per beat: register file, data memory, PC.
// ----------------------------------------------------------------------------
//  channel    dir   handshake        beat contents
//  i_instr    in    valid / ready    command, dest/src regs, immediate, target
//  o_result   out   valid / ready    next_pc, redirect, reg_written, value
//
//  One instruction per cycle while ready is high; a result passes stages 1,
//  2 and 3 and the result queue. A load followed at once by an instruction
//  reading the loaded register is held in stage 1 (the load data leaves the
//  data RAM one stage late). After reset the data memory is cleared, ready
//  held low. An 8-entry result queue absorbs output stalls; input ready drops
//  when the queue plus the three pipeline stages would overflow it.
// ----------------------------------------------------------------------------
module toy_cpu_execute_unit import tce_pkg::*; #(
    parameter int REG_COUNT     = 8,
    parameter int MEM_WORDS     = 1024,
    parameter int PROGRAM_DEPTH = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tce_instr_if.sink    i_instr,
    tce_result_if.source o_result
);

    localparam int RW         = $clog2(REG_COUNT);
    localparam int MAW        = $clog2(MEM_WORDS);
    localparam int MEM_SHIFT  = 32 + MAW;
    localparam logic [63:0] MEM_RECIP_FULL =
        ((64'd1 << MEM_SHIFT) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);
    localparam logic [32:0] MEM_RECIP = MEM_RECIP_FULL[32:0];
    localparam bit  PC_WRAPS   = (PROGRAM_DEPTH <= 256);
    localparam int  FIFO_DEPTH = 8;
    localparam int  FAW        = $clog2(FIFO_DEPTH);

    typedef struct packed {
        t_pc   next_pc;
        logic  redirect;
        logic  reg_written;
        t_word write_value;
    } t_result;

    // constant wrap tables
    logic [RW-1:0] w_ridx_tab [REG_FIELD_N];
    t_pc           w_tgt_tab  [2**PC_W];

    for (genvar g = 0; g < REG_FIELD_N; g++) begin : g_ridx
        assign w_ridx_tab[g] = RW'(g % REG_COUNT);
    end
    for (genvar g = 0; g < 2**PC_W; g++) begin : g_tgt
        assign w_tgt_tab[g] = PC_W'(g % PROGRAM_DEPTH);
    end

    // memory clear after reset
    logic           r_clr_active;
    logic [MAW-1:0] r_clr_addr;

    // stage 1: operand read
    logic             r_s1_vld;
    logic [CMD_W-1:0] r_s1_cmd;
    logic [RW-1:0]    r_s1_rd, r_s1_ra, r_s1_rb;
    t_word            r_s1_imm;
    t_pc              r_s1_tgt;
    logic             r_s1_held;
    t_word            r_s1_opa, r_s1_opb;
    logic             r_byp_a_hit, r_byp_b_hit;
    t_word            r_byp_data;
    logic             r_s1_a_vld, r_s1_b_vld;

    // stage 2: memory access
    logic          r_s2_vld;
    logic [RW-1:0] r_s2_rd;
    logic          r_s2_wrote, r_s2_ld, r_s2_st, r_s2_taken;
    t_word         r_s2_value, r_s2_va, r_s2_vb, r_s2_quot;
    t_pc           r_s2_pc;

    // stage 3: write back
    logic          r_s3_vld;
    logic [RW-1:0] r_s3_rd;
    logic          r_s3_wrote, r_s3_ld, r_s3_taken;
    t_word         r_s3_value;
    t_pc           r_s3_pc;

    logic [REG_COUNT-1:0] r_rf_vld;
    t_pc                  r_pc;

    t_result      r_fifo [FIFO_DEPTH];
    logic [FAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FAW:0]   r_fifo_cnt;

    logic          w_accept, w_hold, w_pop;
    logic [RW-1:0] w_in_rd, w_in_ra, w_in_rb;
    t_word         w_rf_a_rdata, w_rf_b_rdata, w_mem_rdata;
    logic          w_rf_we;
    t_word         w_s3_value;
    t_word         w_base_a, w_base_b, w_va, w_vb;
    logic          w_haz_a, w_haz_b;
    logic          w_wrote, w_ld, w_st, w_taken;
    t_word         w_value;
    t_pc           w_next_pc;
    logic [PC_W:0] w_pc_inc;
    logic [95:0]   w_prod;
    t_word         w_mem_off;
    logic [MAW-1:0] w_mem_addr;
    logic [FAW+1:0] w_occupancy;

    assign w_in_rd = w_ridx_tab[i_instr.dest_reg];
    assign w_in_ra = w_ridx_tab[i_instr.src_a_reg];
    assign w_in_rb = w_ridx_tab[i_instr.src_b_reg];

    assign w_occupancy = (FAW+2)'(r_fifo_cnt) + (FAW+2)'(r_s1_vld)
                       + (FAW+2)'(r_s2_vld) + (FAW+2)'(r_s3_vld);
    assign i_instr.ready = !r_clr_active && !w_hold
                         && (w_occupancy < (FAW+2)'(FIFO_DEPTH));
    assign w_accept = i_instr.valid && i_instr.ready;

    // register file: two copies, one per read port
    assign w_s3_value = r_s3_ld ? w_mem_rdata : r_s3_value;
    assign w_rf_we    = r_s3_vld && r_s3_wrote;

    tce_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (w_rf_we),
        .i_waddr (r_s3_rd),
        .i_wdata (w_s3_value),
        .i_re    (w_accept),
        .i_raddr (w_in_ra),
        .o_rdata (w_rf_a_rdata)
    );

    tce_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (w_rf_we),
        .i_waddr (r_s3_rd),
        .i_wdata (w_s3_value),
        .i_re    (w_accept),
        .i_raddr (w_in_rb),
        .o_rdata (w_rf_b_rdata)
    );

    // operand resolve: stage 2 result, then stage 3, then what was read
    always_comb begin
        if (r_s1_held) begin
            w_base_a = r_s1_opa;
        end else if (r_byp_a_hit) begin
            w_base_a = r_byp_data;
        end else if (r_s1_a_vld) begin
            w_base_a = w_rf_a_rdata;
        end else begin
            w_base_a = '0;
        end
        if (r_s1_held) begin
            w_base_b = r_s1_opb;
        end else if (r_byp_b_hit) begin
            w_base_b = r_byp_data;
        end else if (r_s1_b_vld) begin
            w_base_b = w_rf_b_rdata;
        end else begin
            w_base_b = '0;
        end

        w_haz_a = r_s2_vld && r_s2_ld && (r_s2_rd == r_s1_ra);
        w_haz_b = r_s2_vld && r_s2_ld && (r_s2_rd == r_s1_rb);

        if (r_s2_vld && r_s2_wrote && (r_s2_rd == r_s1_ra)) begin
            w_va = r_s2_value;
        end else if (r_s3_vld && r_s3_wrote && (r_s3_rd == r_s1_ra)) begin
            w_va = w_s3_value;
        end else begin
            w_va = w_base_a;
        end
        if (r_s2_vld && r_s2_wrote && (r_s2_rd == r_s1_rb)) begin
            w_vb = r_s2_value;
        end else if (r_s3_vld && r_s3_wrote && (r_s3_rd == r_s1_rb)) begin
            w_vb = w_s3_value;
        end else begin
            w_vb = w_base_b;
        end
    end

    // load-use: hold stage 1 until the load data is out of the RAM
    assign w_hold = r_s1_vld && (w_haz_a || w_haz_b);

    always_comb begin
        w_wrote = 1'b0;
        w_ld    = 1'b0;
        w_st    = 1'b0;
        w_taken = 1'b0;
        w_value = '0;
        case (r_s1_cmd)
            CMD_LD: begin
                w_wrote = 1'b1;
                w_ld    = 1'b1;
            end
            CMD_ST: begin
                w_st = 1'b1;
            end
            CMD_ADD: begin
                w_wrote = 1'b1;
                w_value = w_va + w_vb;
            end
            CMD_IMM: begin
                w_wrote = 1'b1;
                w_value = r_s1_imm;
            end
            CMD_JMP: begin
                w_taken = 1'b1;
            end
            CMD_BNE: begin
                w_taken = (w_va != w_vb);
            end
            default: begin
                w_taken = 1'b0;
            end
        endcase
    end

    assign w_pc_inc = {1'b0, r_pc} + (PC_W+1)'(1);
    always_comb begin
        if (w_taken) begin
            w_next_pc = w_tgt_tab[r_s1_tgt];
        end else if (PC_WRAPS && (w_pc_inc == (PC_W+1)'(PROGRAM_DEPTH))) begin
            w_next_pc = '0;
        end else begin
            w_next_pc = w_pc_inc[PC_W-1:0];
        end
    end

    // address modulo: quotient by reciprocal here, remainder in stage 2
    assign w_prod = 96'(w_va) * 96'(MEM_RECIP);

    assign w_mem_off  = r_s2_va - 32'(r_s2_quot * 32'(MEM_WORDS));
    assign w_mem_addr = w_mem_off[MAW-1:0];

    tce_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (r_clr_active || (r_s2_vld && r_s2_st)),
        .i_waddr (r_clr_active ? r_clr_addr : w_mem_addr),
        .i_wdata (r_clr_active ? '0 : r_s2_vb),
        .i_re    (r_s2_vld && r_s2_ld),
        .i_raddr (w_mem_addr),
        .o_rdata (w_mem_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_s1_vld     <= 1'b0;
            r_s1_held    <= 1'b0;
            r_s2_vld     <= 1'b0;
            r_s3_vld     <= 1'b0;
            r_rf_vld     <= '0;
            r_pc         <= '0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_fifo_cnt   <= '0;
        end else begin
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + MAW'(1);
                if (r_clr_addr == MAW'(MEM_WORDS - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end

            if (w_accept) begin
                r_s1_vld  <= 1'b1;
                r_s1_held <= 1'b0;
            end else if (w_hold) begin
                r_s1_held <= 1'b1;
            end else begin
                r_s1_vld <= 1'b0;
            end

            r_s2_vld <= r_s1_vld && !w_hold;
            r_s3_vld <= r_s2_vld;

            if (r_s1_vld && !w_hold) begin
                r_pc <= w_next_pc;
            end
            if (w_rf_we) begin
                r_rf_vld[r_s3_rd] <= 1'b1;
            end

            if (r_s3_vld) begin
                r_wr_ptr <= r_wr_ptr + FAW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FAW'(1);
            end
            r_fifo_cnt <= r_fifo_cnt + (FAW+1)'(r_s3_vld) - (FAW+1)'(w_pop);
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_cmd    <= i_instr.command;
            r_s1_rd     <= w_in_rd;
            r_s1_ra     <= w_in_ra;
            r_s1_rb     <= w_in_rb;
            r_s1_imm    <= i_instr.immediate;
            r_s1_tgt    <= i_instr.jump_target;
            // catch the write landing at the same edge as the RAM read
            r_byp_a_hit <= w_rf_we && (r_s3_rd == w_in_ra);
            r_byp_b_hit <= w_rf_we && (r_s3_rd == w_in_rb);
            r_byp_data  <= w_s3_value;
            r_s1_a_vld  <= r_rf_vld[w_in_ra];
            r_s1_b_vld  <= r_rf_vld[w_in_rb];
        end else if (w_hold) begin
            r_s1_opa <= w_va;
            r_s1_opb <= w_vb;
        end

        if (r_s1_vld && !w_hold) begin
            r_s2_rd    <= r_s1_rd;
            r_s2_wrote <= w_wrote;
            r_s2_ld    <= w_ld;
            r_s2_st    <= w_st;
            r_s2_taken <= w_taken;
            r_s2_value <= w_value;
            r_s2_va    <= w_va;
            r_s2_vb    <= w_vb;
            r_s2_quot  <= w_prod[MEM_SHIFT +: 32];
            r_s2_pc    <= w_next_pc;
        end

        if (r_s2_vld) begin
            r_s3_rd    <= r_s2_rd;
            r_s3_wrote <= r_s2_wrote;
            r_s3_ld    <= r_s2_ld;
            r_s3_taken <= r_s2_taken;
            r_s3_value <= r_s2_value;
            r_s3_pc    <= r_s2_pc;
        end

        if (r_s3_vld) begin
            r_fifo[r_wr_ptr] <= '{next_pc:     r_s3_pc,
                                  redirect:    r_s3_taken,
                                  reg_written: r_s3_wrote,
                                  write_value: w_s3_value};
        end
    end

    assign o_result.valid       = (r_fifo_cnt != '0);
    assign w_pop                = o_result.valid && o_result.ready;
    assign o_result.next_pc     = r_fifo[r_rd_ptr].next_pc;
    assign o_result.redirect    = r_fifo[r_rd_ptr].redirect;
    assign o_result.reg_written = r_fifo[r_rd_ptr].reg_written;
    assign o_result.write_value = r_fifo[r_rd_ptr].write_value;

endmodule
